// ===== design/sjf_ready_queue_with_burst_estimate_assert.svh =====
// Assertion macros shared by the checker of the SJF ready queue.
// No dependencies; include by bare file name.
`ifndef SJF_READY_QUEUE_WITH_BURST_ESTIMATE_ASSERT_SVH
`define SJF_READY_QUEUE_WITH_BURST_ESTIMATE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SJFQ_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define SJFQ_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/sjfq_pkg.sv =====
// Package for the SJF ready queue: constants, status codes, register indexes
// and the controller-to-datapath command struct. No dependencies.
`default_nettype none

package sjfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int ID_W    = 16;
    localparam int EST_W   = 32;
    localparam int ALPHA_W = 9;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DATA_W = 32;
    localparam int ACC_W   = 40;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 9'd256;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'd128;
    localparam logic [EST_W-1:0]   INIT_EST_RESET = 32'd10000;
    localparam logic [ACC_W-1:0]   ROUND_HALF  = 40'd128;

    typedef logic [1:0] status_t;
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_EST = 8'd1;

    typedef struct packed {
        logic load;        // capture the accepted item
        logic mul_first;   // acc = prev * a + half
        logic mul_second;  // acc += burst * (1 - a)
        logic commit;      // update queue, load result register
    } dp_cmd_t;

endpackage

`default_nettype wire

// ===== design/sjfq_ctrl.sv =====
// Controller FSM of the SJF ready queue: sequences accept, two multiply
// passes (enqueue only; a dequeue skips them) and the commit. Depends on sjfq_pkg.
`default_nettype none

module sjfq_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_action,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sjfq_pkg::dp_cmd_t     cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = (s_action == sjfq_pkg::ACT_DEQUEUE) ? S_EXEC : S_MUL0;
                end
            end
            S_MUL0: begin
                cmd.mul_first = 1'b1;
                state_next    = S_MUL1;
            end
            S_MUL1: begin
                cmd.mul_second = 1'b1;
                state_next     = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

// ===== design/sjfq_datapath.sv =====
// Datapath of the SJF ready queue: config registers, shared multiplier for
// the estimate blend, the sorted row of queue cells and the result register.
// Depends on sjfq_pkg.
`default_nettype none

module sjfq_datapath #(
    parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire sjfq_pkg::dp_cmd_t                   cmd,
    input  wire logic                                cfg_wr,
    input  wire logic [sjfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sjfq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_action,
    input  wire logic [sjfq_pkg::ID_W-1:0]           s_process_id,
    input  wire logic                                s_is_new,
    input  wire logic [sjfq_pkg::EST_W-1:0]          s_prior_estimate,
    input  wire logic [sjfq_pkg::EST_W-1:0]          s_last_burst,
    output logic [sjfq_pkg::ID_W-1:0]                m_served_id,
    output logic [sjfq_pkg::EST_W-1:0]               m_served_estimate,
    output sjfq_pkg::status_t                        m_status
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W  = sjfq_pkg::ID_W;
    localparam int EST_W = sjfq_pkg::EST_W;
    localparam int AL_W  = sjfq_pkg::ALPHA_W;
    localparam int ACC_W = sjfq_pkg::ACC_W;
    localparam int PROD_W = EST_W + AL_W;

    logic [AL_W-1:0]   alpha_reg;
    logic [EST_W-1:0]  init_est_reg;

    logic              is_deq_reg;
    logic [ID_W-1:0]   pid_reg;
    logic [EST_W-1:0]  op_prev_reg;
    logic [EST_W-1:0]  op_burst_reg;
    logic [ACC_W-1:0]  acc_reg, acc_next;

    logic [AL_W-1:0]   a_sat;
    logic [EST_W-1:0]  mul_x;
    logic [AL_W-1:0]   mul_y;
    logic [PROD_W-1:0] product;
    logic [EST_W-1:0]  new_est;

    logic [ID_W-1:0]   id_reg   [QUEUE_DEPTH];
    logic [EST_W-1:0]  est_reg  [QUEUE_DEPTH];
    logic [ID_W-1:0]   id_next  [QUEUE_DEPTH];
    logic [EST_W-1:0]  est_next [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] ins;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              full, empty;

    logic [ID_W-1:0]   out_id_reg;
    logic [EST_W-1:0]  out_est_reg;
    sjfq_pkg::status_t out_status_reg;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg    <= sjfq_pkg::ALPHA_RESET;
            init_est_reg <= sjfq_pkg::INIT_EST_RESET;
        end else if (cfg_wr) begin
            if (cfg_index == sjfq_pkg::CFG_ALPHA) begin
                alpha_reg <= cfg_data[AL_W-1:0];
            end else if (cfg_index == sjfq_pkg::CFG_INIT_EST) begin
                init_est_reg <= cfg_data[EST_W-1:0];
            end
        end
    end

    // estimate blend: one shared 32x9 multiplier, two passes
    assign a_sat   = (alpha_reg > sjfq_pkg::ALPHA_ONE) ? sjfq_pkg::ALPHA_ONE : alpha_reg;
    assign mul_x   = cmd.mul_first ? op_prev_reg : op_burst_reg;
    assign mul_y   = cmd.mul_first ? a_sat : (sjfq_pkg::ALPHA_ONE - a_sat);
    assign product = PROD_W'(mul_x) * PROD_W'(mul_y);

    always_comb begin
        acc_next = acc_reg;
        if (cmd.mul_first) begin
            acc_next = product[ACC_W-1:0] + sjfq_pkg::ROUND_HALF;
        end else if (cmd.mul_second) begin
            acc_next = acc_reg + product[ACC_W-1:0];
        end
    end

    assign new_est = acc_reg[ACC_W-1:ACC_W-EST_W];

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            is_deq_reg   <= (s_action == sjfq_pkg::ACT_DEQUEUE);
            pid_reg      <= s_process_id;
            op_prev_reg  <= s_is_new ? init_est_reg : s_prior_estimate;
            op_burst_reg <= s_is_new ? '0 : s_last_burst;
        end
        acc_reg <= acc_next;
    end

    // queue cells, kept sorted ascending; ins[k] marks cells at or after the
    // insertion point (first valid entry strictly greater, else the tail)
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        assign ins[k] = (CNT_W'(k) >= count_reg) || (est_reg[k] > new_est);

        always_comb begin
            id_next[k]  = id_reg[k];
            est_next[k] = est_reg[k];
            if (cmd.commit) begin
                if (is_deq_reg) begin
                    if (!empty) begin
                        if (k < QUEUE_DEPTH - 1) begin
                            id_next[k]  = id_reg[(k + 1) % QUEUE_DEPTH];
                            est_next[k] = est_reg[(k + 1) % QUEUE_DEPTH];
                        end
                    end
                end else if (!full && ins[k]) begin
                    if (k == 0 || !ins[(k + QUEUE_DEPTH - 1) % QUEUE_DEPTH]) begin
                        id_next[k]  = pid_reg;
                        est_next[k] = new_est;
                    end else begin
                        id_next[k]  = id_reg[(k + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                        est_next[k] = est_reg[(k + QUEUE_DEPTH - 1) % QUEUE_DEPTH];
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            id_reg[k]  <= id_next[k];
            est_reg[k] <= est_next[k];
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd.commit) begin
            if (is_deq_reg) begin
                if (!empty) begin
                    count_next = count_reg - 1'b1;
                end
            end else if (!full) begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            if (is_deq_reg) begin
                if (empty) begin
                    out_id_reg     <= '0;
                    out_est_reg    <= '0;
                    out_status_reg <= sjfq_pkg::ST_EMPTY;
                end else begin
                    out_id_reg     <= id_reg[0];
                    out_est_reg    <= est_reg[0];
                    out_status_reg <= sjfq_pkg::ST_OK;
                end
            end else begin
                out_id_reg     <= pid_reg;
                out_est_reg    <= new_est;
                out_status_reg <= full ? sjfq_pkg::ST_FULL : sjfq_pkg::ST_OK;
            end
        end
    end

    assign m_served_id       = out_id_reg;
    assign m_served_estimate = out_est_reg;
    assign m_status          = out_status_reg;

endmodule

`default_nettype wire

// ===== design/sjf_ready_queue_with_burst_estimate.sv =====
// Enqueue: two passes of the shared 32x9 multiplier (S_MUL0, S_MUL1), then the
// sorted insert and the result in S_EXEC; the next item is taken back in S_IDLE.
// Dequeue: goes from accept straight to S_EXEC for the commit and the result.
// A waiting result stalls the commit, and no next item is accepted until the commit.
// Reset clears control, count and config; queue entries are not cleared.
`default_nettype none

module sjf_ready_queue_with_burst_estimate #(
    parameter int QUEUE_DEPTH = sjfq_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sjfq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [sjfq_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_action,
    input  wire logic [sjfq_pkg::ID_W-1:0]           s_process_id,
    input  wire logic                                s_is_new,
    input  wire logic [sjfq_pkg::EST_W-1:0]          s_prior_estimate,
    input  wire logic [sjfq_pkg::EST_W-1:0]          s_last_burst,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [sjfq_pkg::ID_W-1:0]                m_served_id,
    output logic [sjfq_pkg::EST_W-1:0]               m_served_estimate,
    output logic [1:0]                               m_status
);

    sjfq_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sjfq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .cmd      (cmd)
    );

    sjfq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .cfg_wr            (cfg_valid && cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_action          (s_action),
        .s_process_id      (s_process_id),
        .s_is_new          (s_is_new),
        .s_prior_estimate  (s_prior_estimate),
        .s_last_burst      (s_last_burst),
        .m_served_id       (m_served_id),
        .m_served_estimate (m_served_estimate),
        .m_status          (m_status)
    );

endmodule

`default_nettype wire

// ===== design/sjfq_checker.sv =====
// Port-level checker for the SJF ready queue, bound to the top level.
// Depends on sjfq_pkg and sjf_ready_queue_with_burst_estimate_assert.svh.
`default_nettype none

`include "sjf_ready_queue_with_burst_estimate_assert.svh"

module sjfq_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_valid,
    input wire logic                             s_ready,
    input wire logic                             m_valid,
    input wire logic                             m_ready,
    input wire logic [sjfq_pkg::ID_W-1:0]        m_served_id,
    input wire logic [sjfq_pkg::EST_W-1:0]       m_served_estimate,
    input wire logic [1:0]                       m_status
);

    // a stalled result holds
    `SJFQ_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_served_id) && $stable(m_served_estimate) && $stable(m_status), "result changed while stalled")

    // one item in flight: input closes right after an accept
    `SJFQ_ASSERT_NEXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready, "second item accepted while busy")

    `SJFQ_ASSERT_NOW(a_status_code, aclk, aresetn, m_valid, m_status == sjfq_pkg::ST_OK || m_status == sjfq_pkg::ST_FULL || m_status == sjfq_pkg::ST_EMPTY, "illegal status code")

    `SJFQ_ASSERT_NOW(a_empty_zero, aclk, aresetn, m_valid && m_status == sjfq_pkg::ST_EMPTY, m_served_id == '0 && m_served_estimate == '0, "empty dequeue returned data")

endmodule

bind sjf_ready_queue_with_burst_estimate sjfq_checker u_sjfq_checker (.*);

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the SJF ready queue with burst estimates.
// Holds its own sorted-queue predictor; depends only on sjfq_pkg and the top level RTL.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ID_W       = sjfq_pkg::ID_W;
    localparam int EST_W      = sjfq_pkg::EST_W;
    localparam int ALPHA_W    = sjfq_pkg::ALPHA_W;
    localparam int CFG_IDX_W  = sjfq_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = sjfq_pkg::CFG_DATA_W;

    localparam int DEPTH         = sjfq_pkg::QUEUE_DEPTH_DEF;
    localparam int N_PHASES      = 16;
    localparam int PHASE_ITEMS   = 50;
    localparam int HOLD_PHASE    = 6;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 4000;
    localparam int CFG_UNUSED_LO = int'(sjfq_pkg::CFG_INIT_EST) + 1;
    localparam int CFG_IDX_MAX   = (1 << CFG_IDX_W) - 1;

    typedef struct packed {
        logic             action;
        logic [ID_W-1:0]  pid;
        logic             is_new;
        logic [EST_W-1:0] prior;
        logic [EST_W-1:0] burst;
    } sched_req_t;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [EST_W-1:0] est;
    } ready_entry_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [EST_W-1:0]  est;
        sjfq_pkg::status_t status;
    } served_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic             s_valid          = 1'b0;
    logic             s_ready;
    logic             s_action         = sjfq_pkg::ACT_ENQUEUE;
    logic [ID_W-1:0]  s_process_id     = '0;
    logic             s_is_new         = 1'b0;
    logic [EST_W-1:0] s_prior_estimate = '0;
    logic [EST_W-1:0] s_last_burst     = '0;

    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [ID_W-1:0]  m_served_id;
    logic [EST_W-1:0] m_served_estimate;
    logic [1:0]       m_status;

    sjf_ready_queue_with_burst_estimate dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_action          (s_action),
        .s_process_id      (s_process_id),
        .s_is_new          (s_is_new),
        .s_prior_estimate  (s_prior_estimate),
        .s_last_burst      (s_last_burst),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_served_id       (m_served_id),
        .m_served_estimate (m_served_estimate),
        .m_status          (m_status)
    );

    // predictor state
    logic [ALPHA_W-1:0] alpha_m    = sjfq_pkg::ALPHA_RESET;
    logic [EST_W-1:0]   init_est_m = sjfq_pkg::INIT_EST_RESET;
    ready_entry_t       ready_list[$];

    sched_req_t sched_requests[$];
    served_t    expected_served[$];

    logic item_taken = 1'b0;
    bit   steady     = 1'b0;
    int   hold_asked = 0;
    int   fail_count = 0;

    int n_enq = 0, n_deq = 0, n_full = 0, n_empty = 0, n_checked = 0, n_cfg = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [EST_W-1:0] blend_estimate(logic [EST_W-1:0] prev,
                                                         logic [EST_W-1:0] burst);
        logic [63:0] w;
        logic [63:0] acc;
        w = (alpha_m > sjfq_pkg::ALPHA_ONE) ? {55'd0, sjfq_pkg::ALPHA_ONE}
                                            : {55'd0, alpha_m};
        acc = {32'd0, prev} * w + {32'd0, burst} * (64'd256 - w) + 64'd128;
        return acc[39:8];
    endfunction

    function automatic served_t serve_request(sched_req_t r);
        served_t      res;
        ready_entry_t ent;
        int           pos;
        if (r.action == sjfq_pkg::ACT_ENQUEUE) begin
            n_enq++;
            res.id  = r.pid;
            res.est = r.is_new ? blend_estimate(init_est_m, '0)
                               : blend_estimate(r.prior, r.burst);
            res.status = sjfq_pkg::ST_OK;
            if (ready_list.size() >= DEPTH) begin
                res.status = sjfq_pkg::ST_FULL;
                n_full++;
            end else begin
                // equal estimates: newcomer goes behind all of them
                pos = 0;
                while (pos < ready_list.size() && ready_list[pos].est <= res.est)
                    pos++;
                ent.id  = r.pid;
                ent.est = res.est;
                ready_list.insert(pos, ent);
            end
        end else begin
            n_deq++;
            if (ready_list.size() == 0) begin
                res = '{id: '0, est: '0, status: sjfq_pkg::ST_EMPTY};
                n_empty++;
            end else begin
                ent = ready_list.pop_front();
                res = '{id: ent.id, est: ent.est, status: sjfq_pkg::ST_OK};
            end
        end
        return res;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // accepted items, config writes and results, all sampled at the rising edge
    always @(posedge aclk) begin
        sched_req_t r;
        served_t    want;
        item_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                n_cfg++;
                if (cfg_index == sjfq_pkg::CFG_ALPHA)
                    alpha_m = cfg_data[ALPHA_W-1:0];
                else if (cfg_index == sjfq_pkg::CFG_INIT_EST)
                    init_est_m = cfg_data;
            end
            if (s_valid && s_ready) begin
                r = '{action: s_action, pid: s_process_id, is_new: s_is_new,
                      prior: s_prior_estimate, burst: s_last_burst};
                expected_served.push_back(serve_request(r));
            end
            if (m_valid && m_ready) begin
                if (expected_served.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result id %0h est %0h status %0d",
                             $time, m_served_id, m_served_estimate, m_status);
                end else begin
                    want = expected_served.pop_front();
                    n_checked++;
                    compare_field("served_id", {16'd0, want.id}, {16'd0, m_served_id});
                    compare_field("served_estimate", want.est, m_served_estimate);
                    compare_field("status", {30'd0, want.status}, {30'd0, m_status});
                end
            end
        end
    end

    // item driver
    int tx_gap = 0;
    always @(negedge aclk) begin
        sched_req_t r;
        if (aresetn && (!s_valid || item_taken)) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (sched_requests.size() > 0) begin
                r = sched_requests.pop_front();
                s_action         <= r.action;
                s_process_id     <= r.pid;
                s_is_new         <= r.is_new;
                s_prior_estimate <= r.prior;
                s_last_burst     <= r.burst;
                s_valid          <= 1'b1;
                tx_gap = steady ? 0 : pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver: random stalls plus the requested long hold-off
    int hold_seen = 0, hold_left = 0, rx_stall = 0;
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = LONG_HOLD;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            rx_stall = pick_gap();
        end
    end

    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("** sjf_ready_queue_with_burst_estimate: FAILED **");
        $finish;
    end

    task automatic enq(input logic [ID_W-1:0] pid, input logic is_new,
                       input logic [EST_W-1:0] prior, input logic [EST_W-1:0] burst);
        sched_requests.push_back('{action: sjfq_pkg::ACT_ENQUEUE, pid: pid, is_new: is_new,
                                   prior: prior, burst: burst});
    endtask

    // dequeue with junk in the ignored fields
    task automatic deq();
        logic [31:0] a, b, c;
        a = $urandom();
        b = $urandom();
        c = $urandom();
        sched_requests.push_back('{action: sjfq_pkg::ACT_DEQUEUE, pid: a[15:0],
                                   is_new: a[16], prior: b, burst: c});
    endtask

    task automatic random_enq(input bit tie_heavy);
        logic [31:0] a, p, q;
        logic [31:0] pool [4];
        pool = '{32'd0, 32'd1, 32'd1000, 32'hFFFF_FFFF};
        a = $urandom();
        if (tie_heavy) begin
            p = pool[$urandom_range(0, 3)];
            q = pool[$urandom_range(0, 3)];
        end else if (a[20]) begin
            p = $urandom();
            q = $urandom();
        end else begin
            p = $urandom_range(0, 3000);
            q = $urandom_range(0, 3000);
        end
        enq(a[15:0], ($urandom_range(0, 4) == 0), p, q);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (sched_requests.size() != 0 || s_valid || expected_served.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int          ph, k, enq_pct;
        bit          tie_heavy;
        logic [31:0] junk, init_val, idx_val;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty dequeue, ties, extremes, fill to full, overflow
        deq();
        enq(16'h0000, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        enq(16'hFFFF, 1'b1, 32'h0, 32'h0);
        enq(16'h0001, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        enq(16'h0002, 1'b0, 32'h0, 32'h0);
        enq(16'h0003, 1'b0, 32'hFFFF_FFFF, 32'h0);
        enq(16'h0004, 1'b0, 32'h0, 32'hFFFF_FFFF);
        enq(16'h0005, 1'b0, 32'd10000, 32'd0);
        enq(16'h0006, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0);
        for (k = 0; k < 8; k++) random_enq(1'b0);
        enq(16'hBEEF, 1'b0, 32'd7, 32'd9);
        repeat (4) deq();

        for (ph = 0; ph < N_PHASES; ph++) begin
            wait_drained();
            junk = $urandom();
            case (ph)
                0: junk[ALPHA_W-1:0] = '0;
                1: junk[ALPHA_W-1:0] = sjfq_pkg::ALPHA_ONE;
                2: junk[ALPHA_W-1:0] = '1;
                3: junk[ALPHA_W-1:0] = 9'd1;
                4: junk[ALPHA_W-1:0] = 9'd255;
                default: ;
            endcase
            write_reg(sjfq_pkg::CFG_ALPHA, junk);
            case (ph)
                0: init_val = '0;
                1: init_val = '1;
                2: init_val = 32'd1;
                default: init_val = ($urandom_range(0, 1) == 1) ? $urandom()
                                                                : $urandom_range(0, 20000);
            endcase
            write_reg(sjfq_pkg::CFG_INIT_EST, init_val);
            if (ph % 4 == 3) begin
                idx_val = (ph == 3) ? CFG_IDX_MAX : $urandom_range(CFG_UNUSED_LO, CFG_IDX_MAX);
                write_reg(idx_val[CFG_IDX_W-1:0], $urandom());
            end

            steady    = (ph % 5 == 2) || (ph == HOLD_PHASE);
            tie_heavy = ($urandom_range(0, 2) == 0);
            case (ph % 3)
                0: enq_pct = 85;
                1: enq_pct = 50;
                default: enq_pct = 20;
            endcase
            if (ph == HOLD_PHASE) begin
                enq_pct = 90;
                hold_asked++;
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 99) < enq_pct)
                    random_enq(tie_heavy);
                else
                    deq();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("covered %0d enqueues and %0d dequeues, %0d results checked",
                 n_enq, n_deq, n_checked);
        $display("%0d overflow and %0d empty cases, %0d register writes",
                 n_full, n_empty, n_cfg);
        if (fail_count == 0 && expected_served.size() == 0)
            $display("** sjf_ready_queue_with_burst_estimate: PASSED **");
        else
            $display("** sjf_ready_queue_with_burst_estimate: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
